[hdl/spgf_pkg.sv]
// Shared widths, constants and types for the softened pair gravity force unit.
package spgf_pkg;

    localparam int POS_W    = 32;
    localparam int MAG_W    = POS_W + 1;
    localparam int PROD_W   = 2 * POS_W;
    localparam int D2_W     = 66;
    localparam int ROOT_W   = 33;
    localparam int GM_W     = 96;
    localparam int GSEG     = 32;
    localparam int DSEG     = 22;
    localparam int DEN_W    = D2_W + ROOT_W;
    localparam int NUM_W    = 128;
    localparam int QUO_W    = 48;
    localparam int FRC_W    = 48;
    localparam int SQRT_LAT = ROOT_W;
    localparam int DIV_LAT  = QUO_W + 1;
    localparam int PIPE_LAT = 3 + SQRT_LAT + 2 + DIV_LAT + 1;

    localparam logic [POS_W-1:0] GRAVITY_RESET = 32'd65536;
    localparam logic [FRC_W-1:0] FORCE_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [FRC_W-1:0] FORCE_NEG_MAG = 48'h8000_0000_0000;

    typedef enum logic {
        CFG_SOFTENING = 1'b0,
        CFG_GRAVITY   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic       valid;
        logic       singular;
        logic [2:0] neg;
    } t_flags;

    typedef struct packed {
        t_flags                     flags;
        logic [2:0][MAG_W-1:0]      mag;
        logic [D2_W-1:0]            d2;
        logic [GM_W-1:0]            gm;
    } t_sq_side;

endpackage

[hdl/spgf_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
module spgf_sqrt (
    input  logic                           i_clk,
    input  logic [spgf_pkg::D2_W-1:0]      i_val,
    output logic [spgf_pkg::ROOT_W-1:0]    o_root
);
    import spgf_pkg::*;

    localparam int TW = D2_W + 2;

    logic [D2_W-1:0]   r_rem [SQRT_LAT];
    logic [ROOT_W-1:0] r_res [SQRT_LAT];

    for (genvar j = 0; j < SQRT_LAT; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;
        logic [D2_W-1:0]   w_rem_prev;
        logic [ROOT_W-1:0] w_res_prev;
        logic [TW-1:0]     w_trial;
        logic [TW-1:0]     w_rem_ext;

        if (j == 0) begin : g_first
            assign w_rem_prev = i_val;
            assign w_res_prev = '0;
        end else begin : g_next
            assign w_rem_prev = r_rem[j-1];
            assign w_res_prev = r_res[j-1];
        end

        assign w_trial   = ({{(TW-ROOT_W){1'b0}}, w_res_prev} << (B + 1))
                         | (TW'(1) << (2 * B));
        assign w_rem_ext = {2'b00, w_rem_prev};

        always_ff @(posedge i_clk) begin
            if (w_trial <= w_rem_ext) begin
                r_rem[j] <= D2_W'(w_rem_ext - w_trial);
                r_res[j] <= w_res_prev | (ROOT_W'(1) << B);
            end else begin
                r_rem[j] <= w_rem_prev;
                r_res[j] <= w_res_prev;
            end
        end
    end

    assign o_root = r_res[SQRT_LAT-1];

endmodule

[hdl/spgf_div.sv]
// Pipelined restoring divider giving a 48-bit quotient and an overflow flag.
module spgf_div (
    input  logic                           i_clk,
    input  logic [spgf_pkg::NUM_W-1:0]     i_num,
    input  logic [spgf_pkg::DEN_W-1:0]     i_den,
    output logic [spgf_pkg::QUO_W-1:0]     o_quo,
    output logic                           o_ovf
);
    import spgf_pkg::*;

    localparam int HI_W = NUM_W - QUO_W;

    logic [DEN_W-1:0] r_rem [DIV_LAT];
    logic [QUO_W-1:0] r_low [DIV_LAT];
    logic [QUO_W-1:0] r_quo [DIV_LAT];
    logic [DEN_W-1:0] r_den [DIV_LAT];
    logic             r_ovf [DIV_LAT];

    always_ff @(posedge i_clk) begin
        r_ovf[0] <= {{(DEN_W-HI_W){1'b0}}, i_num[NUM_W-1:QUO_W]} >= i_den;
        r_rem[0] <= DEN_W'(i_num[NUM_W-1:QUO_W]);
        r_low[0] <= i_num[QUO_W-1:0];
        r_quo[0] <= '0;
        r_den[0] <= i_den;
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic [DEN_W:0] w_sh;
        logic           w_take;

        assign w_sh   = {r_rem[j], r_low[j][QUO_W-1]};
        assign w_take = w_sh >= {1'b0, r_den[j]};

        always_ff @(posedge i_clk) begin
            r_rem[j+1] <= w_take ? DEN_W'(w_sh - {1'b0, r_den[j]}) : DEN_W'(w_sh);
            r_low[j+1] <= r_low[j] << 1;
            r_quo[j+1] <= {r_quo[j][QUO_W-2:0], w_take};
            r_den[j+1] <= r_den[j];
            r_ovf[j+1] <= r_ovf[j];
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];
    assign o_ovf = r_ovf[DIV_LAT-1];

endmodule

[hdl/softened_pair_gravity_force_unit.sv]
// Top level of the softened pairwise gravity force pipeline.
//
// An item is taken at each rising edge where start is high and busy is low.
// busy stays low: a new pair of bodies may enter in every cycle.
// Each result appears on the o_ ports for one cycle with o_valid high,
// in the order of the items.
// Throughput is one item per cycle. The latency is set by the three input
// stages, the 33-stage square root, the two-stage wide products, the
// 49-stage divider and the output register.
// The receiver cannot stall the results, so nothing ever backs up.
// The configuration port writes softening length (index 0) or the gravity
// constant (index 1). The user makes writes while idle; it is not enforced.
// Reset clears all valid bits and loads softening 0 and G equal to 1.0.
// When the softened squared distance is zero the beat carries zero force
// with o_singular set; clipped components set o_saturated.
module softened_pair_gravity_force_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [31:0]                       i_cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [31:0]                i_self_x,
    input  logic signed [31:0]                i_self_y,
    input  logic signed [31:0]                i_self_z,
    input  logic [31:0]                       i_self_mass,
    input  logic signed [31:0]                i_other_x,
    input  logic signed [31:0]                i_other_y,
    input  logic signed [31:0]                i_other_z,
    input  logic [31:0]                       i_other_mass,
    output logic                              o_valid,
    output logic signed [47:0]                o_force_x,
    output logic signed [47:0]                o_force_y,
    output logic signed [47:0]                o_force_z,
    output logic                              o_saturated,
    output logic                              o_singular
);
    import spgf_pkg::*;

    logic [POS_W-1:0] r_softening_length;
    logic [POS_W-1:0] r_gravity_constant;

    logic             n_accept;
    logic [POS_W-1:0] n_self [3];
    logic [POS_W-1:0] n_other [3];
    logic [MAG_W-1:0] n_diff [3];
    logic [MAG_W-1:0] n_mag [3];
    logic [2:0]       n_neg;
    logic             n_sing;

    t_flags            r_f1;
    logic [MAG_W-1:0]  r_mag1 [3];
    logic [PROD_W-1:0] r_eps2_1;
    logic [PROD_W-1:0] r_gm1;
    logic [POS_W-1:0]  r_mo1;

    t_flags            r_f2;
    logic [MAG_W-1:0]  r_mag2 [3];
    logic [D2_W-1:0]   r_sq2 [3];
    logic [PROD_W-1:0] r_eps2_2;
    logic [PROD_W-1:0] r_gmlo2;
    logic [PROD_W-1:0] r_gmhi2;

    t_sq_side          r_s3;
    t_sq_side          r_sq_side [SQRT_LAT];
    logic [ROOT_W-1:0] n_root;

    t_flags                  r_fa;
    logic [DSEG+ROOT_W-1:0]  r_a_den [3];
    logic [GSEG+MAG_W-1:0]   r_a_num [3][3];

    t_flags            r_fb;
    logic [DEN_W-1:0]  r_b_den;
    logic [NUM_W-1:0]  r_b_num [3];

    t_flags            r_dv_side [DIV_LAT];
    logic [QUO_W-1:0]  n_quo [3];
    logic              n_ovf [3];
    logic [FRC_W-1:0]  n_force [3];
    logic              n_sat;

    logic              r_valid;
    logic [FRC_W-1:0]  r_force [3];
    logic              r_saturated;
    logic              r_singular;

    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_softening_length <= '0;
            r_gravity_constant <= GRAVITY_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SOFTENING: r_softening_length <= i_cfg_data;
                CFG_GRAVITY:   r_gravity_constant <= i_cfg_data;
                default:       r_gravity_constant <= r_gravity_constant;
            endcase
        end
    end

    assign n_self[0]  = i_self_x;
    assign n_self[1]  = i_self_y;
    assign n_self[2]  = i_self_z;
    assign n_other[0] = i_other_x;
    assign n_other[1] = i_other_y;
    assign n_other[2] = i_other_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_diff[k] = {n_other[k][POS_W-1], n_other[k]}
                      - {n_self[k][POS_W-1], n_self[k]};
            n_neg[k]  = n_diff[k][MAG_W-1];
            n_mag[k]  = n_neg[k] ? (MAG_W'(0) - n_diff[k]) : n_diff[k];
        end
        n_sing = (n_mag[0] == '0) && (n_mag[1] == '0) && (n_mag[2] == '0)
              && (r_softening_length == '0);
    end

    always_ff @(posedge i_clk) begin
        r_f1.singular <= n_sing;
        r_f1.neg      <= n_neg;
        r_mag1        <= n_mag;
        r_eps2_1      <= PROD_W'(r_softening_length) * PROD_W'(r_softening_length);
        r_gm1         <= PROD_W'(r_gravity_constant) * PROD_W'(i_self_mass);
        r_mo1         <= i_other_mass;

        r_f2.singular <= r_f1.singular;
        r_f2.neg      <= r_f1.neg;
        r_mag2        <= r_mag1;
        for (int k = 0; k < 3; k++) begin
            r_sq2[k] <= D2_W'(r_mag1[k]) * D2_W'(r_mag1[k]);
        end
        r_eps2_2      <= r_eps2_1;
        r_gmlo2       <= PROD_W'(r_gm1[GSEG-1:0]) * PROD_W'(r_mo1);
        r_gmhi2       <= PROD_W'(r_gm1[2*GSEG-1:GSEG]) * PROD_W'(r_mo1);

        r_s3.flags.singular <= r_f2.singular;
        r_s3.flags.neg      <= r_f2.neg;
        for (int k = 0; k < 3; k++) begin
            r_s3.mag[k] <= r_mag2[k];
        end
        r_s3.d2 <= r_sq2[0] + r_sq2[1] + r_sq2[2] + D2_W'(r_eps2_2);
        r_s3.gm <= GM_W'(r_gmlo2) + (GM_W'(r_gmhi2) << GSEG);

        if (!i_rst_n) begin
            r_f1.valid <= 1'b0;
            r_f2.valid <= 1'b0;
            r_s3.flags.valid <= 1'b0;
        end else begin
            r_f1.valid <= n_accept;
            r_f2.valid <= r_f1.valid;
            r_s3.flags.valid <= r_f2.valid;
        end
    end

    spgf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_val  (r_s3.d2),
        .o_root (n_root)
    );

    always_ff @(posedge i_clk) begin
        r_sq_side[0].flags.singular <= r_s3.flags.singular;
        r_sq_side[0].flags.neg      <= r_s3.flags.neg;
        r_sq_side[0].mag            <= r_s3.mag;
        r_sq_side[0].d2             <= r_s3.d2;
        r_sq_side[0].gm             <= r_s3.gm;
        for (int j = 1; j < SQRT_LAT; j++) begin
            r_sq_side[j].flags.singular <= r_sq_side[j-1].flags.singular;
            r_sq_side[j].flags.neg      <= r_sq_side[j-1].flags.neg;
            r_sq_side[j].mag            <= r_sq_side[j-1].mag;
            r_sq_side[j].d2             <= r_sq_side[j-1].d2;
            r_sq_side[j].gm             <= r_sq_side[j-1].gm;
        end

        r_fa.singular <= r_sq_side[SQRT_LAT-1].flags.singular;
        r_fa.neg      <= r_sq_side[SQRT_LAT-1].flags.neg;
        for (int i = 0; i < 3; i++) begin
            r_a_den[i] <= (DSEG+ROOT_W)'(r_sq_side[SQRT_LAT-1].d2[i*DSEG +: DSEG])
                        * (DSEG+ROOT_W)'(n_root);
            for (int k = 0; k < 3; k++) begin
                r_a_num[k][i] <= (GSEG+MAG_W)'(r_sq_side[SQRT_LAT-1].gm[i*GSEG +: GSEG])
                               * (GSEG+MAG_W)'(r_sq_side[SQRT_LAT-1].mag[k]);
            end
        end

        r_fb.singular <= r_fa.singular;
        r_fb.neg      <= r_fa.neg;
        r_b_den <= DEN_W'(r_a_den[0]) + (DEN_W'(r_a_den[1]) << DSEG)
                 + (DEN_W'(r_a_den[2]) << (2 * DSEG));
        for (int k = 0; k < 3; k++) begin
            r_b_num[k] <= NUM_W'(r_a_num[k][0]) + (NUM_W'(r_a_num[k][1]) << GSEG)
                        + (NUM_W'(r_a_num[k][2]) << (2 * GSEG));
        end

        if (!i_rst_n) begin
            for (int j = 0; j < SQRT_LAT; j++) begin
                r_sq_side[j].flags.valid <= 1'b0;
            end
            r_fa.valid <= 1'b0;
            r_fb.valid <= 1'b0;
        end else begin
            r_sq_side[0].flags.valid <= r_s3.flags.valid;
            for (int j = 1; j < SQRT_LAT; j++) begin
                r_sq_side[j].flags.valid <= r_sq_side[j-1].flags.valid;
            end
            r_fa.valid <= r_sq_side[SQRT_LAT-1].flags.valid;
            r_fb.valid <= r_fa.valid;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        spgf_div u_div (
            .i_clk (i_clk),
            .i_num (r_b_num[k]),
            .i_den (r_b_den),
            .o_quo (n_quo[k]),
            .o_ovf (n_ovf[k])
        );
    end

    always_ff @(posedge i_clk) begin
        r_dv_side[0].singular <= r_fb.singular;
        r_dv_side[0].neg      <= r_fb.neg;
        for (int j = 1; j < DIV_LAT; j++) begin
            r_dv_side[j].singular <= r_dv_side[j-1].singular;
            r_dv_side[j].neg      <= r_dv_side[j-1].neg;
        end

        if (!i_rst_n) begin
            for (int j = 0; j < DIV_LAT; j++) begin
                r_dv_side[j].valid <= 1'b0;
            end
            r_valid <= 1'b0;
        end else begin
            r_dv_side[0].valid <= r_fb.valid;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_dv_side[j].valid <= r_dv_side[j-1].valid;
            end
            r_valid <= r_dv_side[DIV_LAT-1].valid;
        end
    end

    always_comb begin
        logic [FRC_W-1:0] lim;
        logic [FRC_W-1:0] m;
        logic             over;
        n_sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            lim  = r_dv_side[DIV_LAT-1].neg[k] ? FORCE_NEG_MAG : FORCE_POS_MAX;
            over = n_ovf[k] || (n_quo[k] > lim);
            m    = over ? lim : n_quo[k];
            n_sat = n_sat | over;
            n_force[k] = r_dv_side[DIV_LAT-1].neg[k] ? (FRC_W'(0) - m) : m;
            if (r_dv_side[DIV_LAT-1].singular) begin
                n_force[k] = '0;
            end
        end
        if (r_dv_side[DIV_LAT-1].singular) begin
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_force     <= n_force;
        r_saturated <= n_sat;
        r_singular  <= r_dv_side[DIV_LAT-1].singular;
    end

    assign o_valid     = r_valid;
    assign o_force_x   = r_force[0];
    assign o_force_y   = r_force[1];
    assign o_force_z   = r_force[2];
    assign o_saturated = r_saturated;
    assign o_singular  = r_singular;

endmodule

[hdl/spgf_chk.sv]
// Port-level checker for the softened pair gravity force unit, with its bind.
module spgf_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [47:0] o_force_x,
    input logic signed [47:0] o_force_y,
    input logic signed [47:0] o_force_z,
    input logic               o_saturated,
    input logic               o_singular
);
    import spgf_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy went high");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result beat without a matching input beat");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |->
            (o_force_x == '0 && o_force_y == '0 && o_force_z == '0 && !o_saturated))
        else $error("singular beat carries nonzero force or saturation");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_force_x == FORCE_POS_MAX || o_force_x == FORCE_NEG_MAG
          || o_force_y == FORCE_POS_MAX || o_force_y == FORCE_NEG_MAG
          || o_force_z == FORCE_POS_MAX || o_force_z == FORCE_NEG_MAG))
        else $error("saturated beat has no component at a limit");

endmodule

bind softened_pair_gravity_force_unit spgf_chk u_spgf_chk (.*);
